// ----- rtl/scrg_pkg.sv -----
package scrg_pkg;

  localparam int ROW_W       = 21;
  localparam int POS_W       = 24;
  localparam int VAL_W       = 20;
  localparam int CFG_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int SIN_N_W     = 23;
  localparam int NB          = 7;
  localparam int SLOT_W      = 3;
  localparam int QUEUE_DEPTH = 2;

  // Slot order of a row: -z, -y, -x, self, +x, +y, +z.
  localparam logic [SLOT_W-1:0] DIAG_SLOT = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_END  = 3'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_e;

  // Fraction of a turn per radian, Q0.64, split in halves.
  localparam logic [31:0] TURN_K_LO   = 32'h9391054A;
  localparam logic [31:0] TURN_K_HI   = 32'h28BE60DB;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  localparam logic [VAL_W-1:0] DIAG_MAX     = 20'd524287;
  localparam logic [22:0]      DIAG_SAT_LIM = 23'd5242880;
  localparam logic [31:0]      RECIP_TEN    = 32'd429496729;
  localparam logic [7:0]       TEN          = 8'd10;
  localparam logic [7:0]       ELEVEN       = 8'd11;
  localparam logic [7:0]       FIVE         = 8'd5;
  localparam logic [2:0]       HORNER_LAST  = 3'd5;

  function automatic logic [7:0] horner_div(input logic [2:0] idx);
    logic [7:0] k;
    case (idx)
      3'd0:    k = 8'd156;
      3'd1:    k = 8'd110;
      3'd2:    k = 8'd72;
      3'd3:    k = 8'd42;
      3'd4:    k = 8'd20;
      3'd5:    k = 8'd6;
      default: k = 8'd6;
    endcase
    return k;
  endfunction

  // floor(2^32 / k) for each Horner divisor.
  function automatic logic [31:0] horner_recip(input logic [2:0] idx);
    logic [31:0] m;
    case (idx)
      3'd0:    m = 32'd27531841;
      3'd1:    m = 32'd39045157;
      3'd2:    m = 32'd59652323;
      3'd3:    m = 32'd102261126;
      3'd4:    m = 32'd214748364;
      3'd5:    m = 32'd715827882;
      default: m = 32'd715827882;
    endcase
    return m;
  endfunction

  typedef struct packed {
    logic [ROW_W-1:0]         row;
    logic [NB-1:0][ROW_W-1:0] col;
    logic [NB-1:0]            ok;
    logic [POS_W-1:0]         base;
    logic                     last_row;
  } row_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic               start;
    logic [SIN_N_W-1:0] n;
  } sin_req_t;

  typedef struct packed {
    logic done;
    logic neg;
  } sin_rsp_t;

  typedef enum logic [3:0] {
    SIN_IDLE,
    SIN_MLO,
    SIN_MHI,
    SIN_FOLD,
    SIN_ANG,
    SIN_SQR,
    SIN_H_MUL,
    SIN_H_RCP,
    SIN_H_FIX,
    SIN_MAG,
    SIN_DONE
  } sin_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_WAIT,
    B_DIV1,
    B_DIV2,
    B_DIV3,
    B_EMIT
  } back_state_e;

endpackage

// ----- rtl/scrg_sine.sv -----
module scrg_sine #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scrg_pkg::sin_req_t   req_i,
  output scrg_pkg::sin_rsp_t   rsp_o,
  output logic [FRAC_BITS+1:0] mag_o
);

  localparam int MW = FRAC_BITS + 2;

  scrg_pkg::sin_state_e state_q, state_d;

  logic [scrg_pkg::SIN_N_W-1:0] n_q;
  logic [54:0] p_lo_q;
  logic [31:0] p_hi_q;
  logic [1:0]  quad_q;
  logic [32:0] u_q;
  logic [30:0] a_q;
  logic [31:0] a2_q;
  logic [30:0] term_q;
  logic [31:0] x_q;
  logic [31:0] qe_q;
  logic [2:0]  hk_q;
  logic [30:0] m30_q;

  logic [54:0] lo_full, hi_full;
  logic [63:0] t_sum;
  logic [32:0] u_raw, u_fold;
  logic [63:0] ang_full;
  logic [61:0] sq_full;
  logic [62:0] hm_full;
  logic [63:0] rc_full;
  logic [39:0] back_mul, rem;
  logic [7:0]  kdiv;
  logic [31:0] qfix;
  logic [61:0] mag_full;
  logic [31:0] rounded;

  always_comb begin
    lo_full  = 55'(n_q) * 55'(scrg_pkg::TURN_K_LO);
    hi_full  = 55'(n_q) * 55'(scrg_pkg::TURN_K_HI);
    t_sum    = {p_hi_q, 32'd0} + {9'd0, p_lo_q};
    u_raw    = {1'b0, t_sum[61:30]};
    // Odd quadrants mirror the angle within the quarter turn.
    u_fold   = t_sum[62] ? (33'h1_0000_0000 - u_raw) : u_raw;
    ang_full = 64'(u_q) * 64'(scrg_pkg::HALF_PI_Q30);
    sq_full  = 62'(a_q) * 62'(a_q);
    hm_full  = 63'(a2_q) * 63'(term_q);
    rc_full  = 64'(x_q) * 64'(scrg_pkg::horner_recip(hk_q));
    kdiv     = scrg_pkg::horner_div(hk_q);
    // The reciprocal estimate is at most one below the true quotient.
    back_mul = 40'(qe_q) * 40'(kdiv);
    rem      = 40'(x_q) - back_mul;
    qfix     = qe_q + 32'(rem >= 40'(kdiv));
    mag_full = 62'(a_q) * 62'(term_q);
    rounded  = (32'(m30_q) + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      scrg_pkg::SIN_IDLE:  if (req_i.start) state_d = scrg_pkg::SIN_MLO;
      scrg_pkg::SIN_MLO:   state_d = scrg_pkg::SIN_MHI;
      scrg_pkg::SIN_MHI:   state_d = scrg_pkg::SIN_FOLD;
      scrg_pkg::SIN_FOLD:  state_d = scrg_pkg::SIN_ANG;
      scrg_pkg::SIN_ANG:   state_d = scrg_pkg::SIN_SQR;
      scrg_pkg::SIN_SQR:   state_d = scrg_pkg::SIN_H_MUL;
      scrg_pkg::SIN_H_MUL: state_d = scrg_pkg::SIN_H_RCP;
      scrg_pkg::SIN_H_RCP: state_d = scrg_pkg::SIN_H_FIX;
      scrg_pkg::SIN_H_FIX: begin
        if (hk_q == scrg_pkg::HORNER_LAST) state_d = scrg_pkg::SIN_MAG;
        else state_d = scrg_pkg::SIN_H_MUL;
      end
      scrg_pkg::SIN_MAG:   state_d = scrg_pkg::SIN_DONE;
      scrg_pkg::SIN_DONE:  state_d = scrg_pkg::SIN_IDLE;
      default:             state_d = scrg_pkg::SIN_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done = (state_q == scrg_pkg::SIN_DONE);
    rsp_o.neg  = quad_q[1];
    mag_o      = MW'(rounded);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scrg_pkg::SIN_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      scrg_pkg::SIN_IDLE: if (req_i.start) n_q <= req_i.n;
      scrg_pkg::SIN_MLO:  p_lo_q <= lo_full;
      scrg_pkg::SIN_MHI:  p_hi_q <= hi_full[31:0];
      scrg_pkg::SIN_FOLD: begin
        quad_q <= t_sum[63:62];
        u_q    <= u_fold;
      end
      scrg_pkg::SIN_ANG:  a_q <= ang_full[62:32];
      scrg_pkg::SIN_SQR: begin
        a2_q   <= sq_full[61:30];
        term_q <= scrg_pkg::ONE_Q30;
        hk_q   <= '0;
      end
      scrg_pkg::SIN_H_MUL: x_q <= hm_full[61:30];
      scrg_pkg::SIN_H_RCP: qe_q <= rc_full[63:32];
      scrg_pkg::SIN_H_FIX: begin
        term_q <= scrg_pkg::ONE_Q30 - qfix[30:0];
        hk_q   <= hk_q + 3'd1;
      end
      scrg_pkg::SIN_MAG:  m30_q <= mag_full[60:30];
      default: ;
    endcase
  end

endmodule

// ----- rtl/scrg_queue.sv -----
module scrg_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  scrg_pkg::row_desc_t   push_data_i,
  input  logic                  pop_i,
  output scrg_pkg::row_desc_t   head_o,
  output scrg_pkg::queue_stat_t stat_o
);

  localparam int Depth = scrg_pkg::QUEUE_DEPTH;
  localparam int PW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNTW  = $clog2(Depth + 1);

  scrg_pkg::row_desc_t slot_q [Depth];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] count_q;

  assign head_o       = slot_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CNTW'(Depth));
  assign stat_o.empty = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) count_q <= count_q + CNTW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CNTW'(1);
    end
  end

endmodule

// ----- rtl/scrg_front.sv -----
module scrg_front #(
  parameter int DIM_MAX = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [scrg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [scrg_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              restart_i,
  input  scrg_pkg::queue_stat_t             q_stat_i,
  output logic                              push_o,
  output scrg_pkg::row_desc_t               desc_o
);

  localparam int CW   = $clog2(DIM_MAX);
  localparam int CMPW = ((CW > 8) ? CW : 8) + 1;
  localparam int RowW = scrg_pkg::ROW_W;
  localparam int PosW = scrg_pkg::POS_W;

  function automatic logic [7:0] clamp_size(input logic [7:0] v);
    logic [7:0] r;
    if (v == 8'd0) r = 8'd1;
    else if (11'(v) > 11'(DIM_MAX)) r = 8'(DIM_MAX);
    else r = v;
    return r;
  endfunction

  logic [7:0] size_x_q, size_y_q, size_z_q;
  logic [CW-1:0] cx_q, cy_q, cz_q;
  logic [RowW-1:0] row_q;
  logic [PosW-1:0] count_q;

  logic [7:0]      sx, sy, sz;
  logic [15:0]     sxy;
  logic [CW-1:0]   cx, cy, cz;
  logic [RowW-1:0] row;
  logic [PosW-1:0] count;
  logic [6:0]      ok;
  logic [2:0]      n_ent;
  logic            last_row;
  logic [CMPW-1:0] cx_inc, cy_inc, cz_inc;
  logic            cfg_hit;

  always_comb begin
    sx  = clamp_size(size_x_q);
    sy  = clamp_size(size_y_q);
    sz  = clamp_size(size_z_q);
    sxy = 16'(sx) * 16'(sy);

    cx    = restart_i ? '0 : cx_q;
    cy    = restart_i ? '0 : cy_q;
    cz    = restart_i ? '0 : cz_q;
    row   = restart_i ? '0 : row_q;
    count = restart_i ? '0 : count_q;

    cx_inc = CMPW'(cx) + CMPW'(1);
    cy_inc = CMPW'(cy) + CMPW'(1);
    cz_inc = CMPW'(cz) + CMPW'(1);

    ok[0] = (cz != '0);
    ok[1] = (cy != '0);
    ok[2] = (cx != '0);
    ok[3] = 1'b1;
    ok[4] = (cx_inc < CMPW'(sx));
    ok[5] = (cy_inc < CMPW'(sy));
    ok[6] = (cz_inc < CMPW'(sz));
    last_row = !ok[4] && !ok[5] && !ok[6];

    n_ent = 3'(ok[0]) + 3'(ok[1]) + 3'(ok[2]) + 3'(ok[3])
          + 3'(ok[4]) + 3'(ok[5]) + 3'(ok[6]);

    desc_o.row      = row;
    desc_o.col[0]   = row - RowW'(sxy);
    desc_o.col[1]   = row - RowW'(sx);
    desc_o.col[2]   = row - RowW'(1);
    desc_o.col[3]   = row;
    desc_o.col[4]   = row + RowW'(1);
    desc_o.col[5]   = row + RowW'(sx);
    desc_o.col[6]   = row + RowW'(sxy);
    desc_o.ok       = ok;
    desc_o.base     = count;
    desc_o.last_row = last_row;

    push_o = in_valid_i && !q_stat_i.full;
  end

  always_comb begin
    case (cfg_index_i)
      scrg_pkg::REG_SIZE_X,
      scrg_pkg::REG_SIZE_Y,
      scrg_pkg::REG_SIZE_Z: cfg_hit = cfg_valid_i;
      default:              cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= 8'd1;
      size_y_q <= 8'd1;
      size_z_q <= 8'd1;
      cx_q     <= '0;
      cy_q     <= '0;
      cz_q     <= '0;
      row_q    <= '0;
      count_q  <= '0;
    end else if (cfg_hit) begin
      case (cfg_index_i)
        scrg_pkg::REG_SIZE_X: size_x_q <= cfg_data_i;
        scrg_pkg::REG_SIZE_Y: size_y_q <= cfg_data_i;
        scrg_pkg::REG_SIZE_Z: size_z_q <= cfg_data_i;
        default: ;
      endcase
      // A write to any size register restarts the walk.
      cx_q    <= '0;
      cy_q    <= '0;
      cz_q    <= '0;
      row_q   <= '0;
      count_q <= '0;
    end else if (push_o) begin
      if (last_row) begin
        cx_q    <= '0;
        cy_q    <= '0;
        cz_q    <= '0;
        row_q   <= '0;
        count_q <= '0;
      end else begin
        count_q <= count + PosW'(n_ent);
        row_q   <= row + RowW'(1);
        if (cx_inc >= CMPW'(sx)) begin
          cx_q <= '0;
          if (cy_inc >= CMPW'(sy)) begin
            cy_q <= '0;
            cz_q <= CW'(cz_inc);
          end else begin
            cy_q <= CW'(cy_inc);
            cz_q <= cz;
          end
        end else begin
          cx_q <= CW'(cx_inc);
          cy_q <= cy;
          cz_q <= cz;
        end
      end
    end
  end

endmodule

// ----- rtl/scrg_back.sv -----
module scrg_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  scrg_pkg::queue_stat_t           q_stat_i,
  input  scrg_pkg::row_desc_t             q_head_i,
  output logic                            pop_o,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [scrg_pkg::ROW_W-1:0]      row_index_o,
  output logic [scrg_pkg::ROW_W-1:0]      column_index_o,
  output logic signed [scrg_pkg::VAL_W-1:0] entry_value_o,
  output logic [scrg_pkg::POS_W-1:0]      entry_position_o,
  output logic                            is_diagonal_o,
  output logic                            last_of_row_o,
  output logic                            last_of_matrix_o
);

  localparam int MW    = FRAC_BITS + 2;
  localparam int SumW  = MW + 3;
  localparam int VW    = (FRAC_BITS + 9 > 23) ? FRAC_BITS + 9 : 23;
  localparam int P10W  = VW + 32;
  localparam int ValW  = scrg_pkg::VAL_W;
  localparam int RowW  = scrg_pkg::ROW_W;
  localparam int PosW  = scrg_pkg::POS_W;
  localparam int SlotW = scrg_pkg::SLOT_W;

  scrg_pkg::back_state_e state_q, state_d;

  scrg_pkg::row_desc_t desc_q;
  logic [SlotW-1:0]    j_q;
  logic [SlotW-1:0]    emit_cnt_q;
  logic [ValW-1:0]     val_q [scrg_pkg::NB];
  logic [SumW-1:0]     sum_q;
  logic [VW-1:0]       v_q;
  logic [VW-1:0]       qe10_q;
  logic [ValW-1:0]     diag_q;

  logic                out_valid_q;
  logic [RowW-1:0]     out_row_q, out_col_q;
  logic [ValW-1:0]     out_val_q;
  logic [PosW-1:0]     out_pos_q;
  logic                out_diag_q, out_lrow_q, out_lmat_q;

  scrg_pkg::sin_req_t  sin_req;
  scrg_pkg::sin_rsp_t  sin_rsp;
  logic [MW-1:0]       sin_mag;

  logic            ok_j, need_sin, slot_free, out_load;
  logic [SlotW-1:0] last_slot;
  logic [ValW-1:0] mag_ext, val_new;
  logic [P10W-1:0] p10;
  logic [VW-1:0]   r10, q10;
  logic            sat;

  scrg_sine #(
    .FRAC_BITS(FRAC_BITS)
  ) u_sine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (sin_req),
    .rsp_o (sin_rsp),
    .mag_o (sin_mag)
  );

  always_comb begin
    ok_j      = (j_q == scrg_pkg::SLOT_END) ? 1'b0 : desc_q.ok[j_q];
    need_sin  = ok_j && (j_q != scrg_pkg::DIAG_SLOT);
    slot_free = !out_valid_q || !out_stall_i;
    if (desc_q.ok[6]) last_slot = 3'd6;
    else if (desc_q.ok[5]) last_slot = 3'd5;
    else if (desc_q.ok[4]) last_slot = 3'd4;
    else last_slot = scrg_pkg::DIAG_SLOT;

    mag_ext = ValW'(sin_mag);
    val_new = sin_rsp.neg ? -mag_ext : mag_ext;

    p10 = P10W'(v_q) * P10W'(scrg_pkg::RECIP_TEN);
    r10 = v_q - VW'(qe10_q * VW'(scrg_pkg::TEN));
    q10 = qe10_q + VW'(r10 >= VW'(scrg_pkg::TEN));
    // A diagonal of 2^19 or more would need v of ten times that.
    sat = (v_q >= VW'(scrg_pkg::DIAG_SAT_LIM));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      scrg_pkg::B_IDLE: if (!q_stat_i.empty) state_d = scrg_pkg::B_SCAN;
      scrg_pkg::B_SCAN: begin
        if (j_q == scrg_pkg::SLOT_END) state_d = scrg_pkg::B_DIV1;
        else if (need_sin) state_d = scrg_pkg::B_WAIT;
      end
      scrg_pkg::B_WAIT: if (sin_rsp.done) state_d = scrg_pkg::B_SCAN;
      scrg_pkg::B_DIV1: state_d = scrg_pkg::B_DIV2;
      scrg_pkg::B_DIV2: state_d = scrg_pkg::B_DIV3;
      scrg_pkg::B_DIV3: state_d = scrg_pkg::B_EMIT;
      scrg_pkg::B_EMIT: begin
        if (ok_j && slot_free && (j_q == last_slot)) state_d = scrg_pkg::B_IDLE;
      end
      default: state_d = scrg_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop_o         = (state_q == scrg_pkg::B_IDLE) && !q_stat_i.empty;
    sin_req.start = (state_q == scrg_pkg::B_SCAN) && need_sin;
    sin_req.n     = scrg_pkg::SIN_N_W'(desc_q.row) + scrg_pkg::SIN_N_W'(desc_q.col[j_q])
                  + scrg_pkg::SIN_N_W'(1);
    out_load      = (state_q == scrg_pkg::B_EMIT) && ok_j && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scrg_pkg::B_IDLE;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        scrg_pkg::B_IDLE: j_q <= '0;
        scrg_pkg::B_SCAN: if (j_q != scrg_pkg::SLOT_END && !need_sin) j_q <= j_q + 3'd1;
        scrg_pkg::B_WAIT: if (sin_rsp.done) j_q <= j_q + 3'd1;
        scrg_pkg::B_DIV3: j_q <= '0;
        scrg_pkg::B_EMIT: if (!ok_j || (out_load && j_q != last_slot)) j_q <= j_q + 3'd1;
        default: ;
      endcase
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      scrg_pkg::B_IDLE: begin
        if (!q_stat_i.empty) desc_q <= q_head_i;
        sum_q      <= '0;
        emit_cnt_q <= '0;
      end
      scrg_pkg::B_WAIT: begin
        if (sin_rsp.done) begin
          val_q[j_q] <= val_new;
          sum_q      <= sum_q + SumW'(sin_mag);
        end
      end
      scrg_pkg::B_DIV1: v_q <= VW'(sum_q) * VW'(scrg_pkg::ELEVEN) + VW'(scrg_pkg::FIVE);
      scrg_pkg::B_DIV2: qe10_q <= p10[P10W-1:32];
      scrg_pkg::B_DIV3: diag_q <= sat ? scrg_pkg::DIAG_MAX : ValW'(q10);
      default: ;
    endcase
    if (out_load) begin
      out_row_q  <= desc_q.row;
      out_col_q  <= desc_q.col[j_q];
      out_val_q  <= (j_q == scrg_pkg::DIAG_SLOT) ? diag_q : val_q[j_q];
      out_pos_q  <= desc_q.base + PosW'(emit_cnt_q);
      out_diag_q <= (j_q == scrg_pkg::DIAG_SLOT);
      out_lrow_q <= (j_q == last_slot);
      out_lmat_q <= (j_q == last_slot) && desc_q.last_row;
      emit_cnt_q <= emit_cnt_q + 3'd1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign row_index_o      = out_row_q;
  assign column_index_o   = out_col_q;
  assign entry_value_o    = out_val_q;
  assign entry_position_o = out_pos_q;
  assign is_diagonal_o    = out_diag_q;
  assign last_of_row_o    = out_lrow_q;
  assign last_of_matrix_o = out_lmat_q;

  a_diag_on_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_diag_q |-> out_col_q == out_row_q)
    else $error("diagonal beat with column different from row");

  a_matrix_end_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_lmat_q |-> out_lrow_q)
    else $error("matrix end flagged on a beat that does not end its row");

  a_sine_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sin_rsp.done |-> state_q == scrg_pkg::B_WAIT)
    else $error("sine result arrived while no entry was waiting for it");

endmodule

// ----- rtl/stencil_csr_row_generator.sv -----
// A row's entries are computed after its tick is taken and its descriptor popped from the queue;
// the iterative sine unit is used once per off-diagonal entry (at most six per row), one at a time.
// The diagonal is then derived from their sum, and the emit state steps through each slot up to
// the row's last entry, held by any output stall. A row is finished before the next is popped.
// A two-deep row queue lets ticks be taken while the previous row is still computed.
// Reset: sizes return to 1, the walk to row 0 with count 0, and the queue empties.
module stencil_csr_row_generator #(
  parameter int DIM_MAX   = 128,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [scrg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [scrg_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              restart_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [scrg_pkg::ROW_W-1:0]        row_index_o,
  output logic [scrg_pkg::ROW_W-1:0]        column_index_o,
  output logic signed [scrg_pkg::VAL_W-1:0] entry_value_o,
  output logic [scrg_pkg::POS_W-1:0]        entry_position_o,
  output logic                              is_diagonal_o,
  output logic                              last_of_row_o,
  output logic                              last_of_matrix_o
);

  scrg_pkg::queue_stat_t q_stat;
  scrg_pkg::row_desc_t   push_desc, head_desc;
  logic                  push, pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_stat.full;

  scrg_front #(
    .DIM_MAX(DIM_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .desc_o     (push_desc)
  );

  scrg_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_desc),
    .pop_i      (pop),
    .head_o     (head_desc),
    .stat_o     (q_stat)
  );

  scrg_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_stat_i        (q_stat),
    .q_head_i        (head_desc),
    .pop_o           (pop),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .row_index_o     (row_index_o),
    .column_index_o  (column_index_o),
    .entry_value_o   (entry_value_o),
    .entry_position_o(entry_position_o),
    .is_diagonal_o   (is_diagonal_o),
    .last_of_row_o   (last_of_row_o),
    .last_of_matrix_o(last_of_matrix_o)
  );

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIMS   = 128;
  localparam int FRAC   = 16;
  localparam int IDLE_LIMIT = 5000;
  localparam int ROW_W     = scrg_pkg::ROW_W;
  localparam int VAL_W     = scrg_pkg::VAL_W;
  localparam int POS_W     = scrg_pkg::POS_W;
  localparam int CFG_W     = scrg_pkg::CFG_W;
  localparam int CFG_IDX_W = scrg_pkg::CFG_IDX_W;
  localparam logic [63:0] TURN_FRAC = {scrg_pkg::TURN_K_HI, scrg_pkg::TURN_K_LO};
  // Register index past the last size register; writes to it are ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        col;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]        pos;
    logic                    diag;
    logic                    row_end;
    logic                    mat_end;
  } entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic restart_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  entry_t got;

  stencil_csr_row_generator u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .restart_i, .out_valid_o, .out_stall_i,
    .row_index_o(got.row), .column_index_o(got.col), .entry_value_o(got.val),
    .entry_position_o(got.pos), .is_diagonal_o(got.diag),
    .last_of_row_o(got.row_end), .last_of_matrix_o(got.mat_end)
  );

  // Stencil walk state kept by the testbench.
  logic [CFG_W-1:0] size_reg [3];
  int unsigned px, py, pz;
  logic [ROW_W-1:0] walk_row;
  logic [POS_W-1:0] walk_count;

  bit     tick_queue[$];
  entry_t pending_entries[$];
  int     errors = 0;
  int     ticks_taken = 0;
  int     entries_seen = 0;
  int     idle_cycles = 0;
  bit     quiet = 1'b0;
  bit     hold_req = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_size(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIMS) return DIMS;
    return v;
  endfunction

  function automatic logic signed [VAL_W-1:0] sine_q16(input logic [63:0] n);
    int unsigned divs [6] = '{156, 110, 72, 42, 20, 6};
    logic [63:0] t, u, a, a2, term, mag;
    t = n * TURN_FRAC;
    u = {32'd0, t[61:30]};
    if (t[62]) u = 64'h1_0000_0000 - u;
    a = (u * 64'(scrg_pkg::HALF_PI_Q30)) >> 32;
    a2 = (a * a) >> 30;
    term = 64'(scrg_pkg::ONE_Q30);
    for (int k = 0; k < 6; k++) begin
      term = 64'(scrg_pkg::ONE_Q30) - ((a2 * term) >> 30) / divs[k];
    end
    mag = (a * term) >> 30;
    mag = (mag + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    return t[63] ? -VAL_W'(mag) : VAL_W'(mag);
  endfunction

  function automatic void restart_walk();
    px = 0; py = 0; pz = 0;
    walk_row = '0;
    walk_count = '0;
  endfunction

  function automatic void predict_row(input bit restart);
    int unsigned sx, sy, sz, n, dslot;
    logic [63:0] row, sxy, sum, dv;
    logic [63:0] cols [7];
    bit ok [7];
    bit last_pt;
    entry_t e [7];
    sx = eff_size(size_reg[scrg_pkg::REG_SIZE_X]);
    sy = eff_size(size_reg[scrg_pkg::REG_SIZE_Y]);
    sz = eff_size(size_reg[scrg_pkg::REG_SIZE_Z]);
    sxy = sx * sy;
    if (restart) restart_walk();
    row = walk_row;
    ok[0] = pz != 0;      cols[0] = row - sxy;
    ok[1] = py != 0;      cols[1] = row - sx;
    ok[2] = px != 0;      cols[2] = row - 1;
    ok[3] = 1'b1;         cols[3] = row;
    ok[4] = px + 1 < sx;  cols[4] = row + 1;
    ok[5] = py + 1 < sy;  cols[5] = row + sx;
    ok[6] = pz + 1 < sz;  cols[6] = row + sxy;
    last_pt = !ok[4] && !ok[5] && !ok[6];
    n = 0; dslot = 0; sum = 0;
    for (int j = 0; j < 7; j++) begin
      if (ok[j]) begin
        e[n].row = row[ROW_W-1:0];
        e[n].col = cols[j][ROW_W-1:0];
        e[n].pos = walk_count + POS_W'(n);
        e[n].diag = (j == int'(scrg_pkg::DIAG_SLOT));
        e[n].row_end = 1'b0;
        e[n].mat_end = 1'b0;
        if (j == int'(scrg_pkg::DIAG_SLOT)) begin
          dslot = n;
          e[n].val = '0;
        end else begin
          e[n].val = sine_q16(row + 64'(e[n].col) + 1);
          sum += (e[n].val < 0) ? 64'(-e[n].val) : 64'(e[n].val);
        end
        n++;
      end
    end
    dv = (11 * sum + 5) / 10;
    if (dv > 64'(scrg_pkg::DIAG_MAX)) dv = 64'(scrg_pkg::DIAG_MAX);
    e[dslot].val = VAL_W'(dv);
    e[n-1].row_end = 1'b1;
    e[n-1].mat_end = last_pt;
    for (int j = 0; j < n; j++) pending_entries.push_back(e[j]);
    if (last_pt) begin
      restart_walk();
    end else begin
      walk_count += POS_W'(n);
      walk_row += 1;
      px++;
      if (px >= sx) begin
        px = 0;
        py++;
        if (py >= sy) begin
          py = 0;
          pz++;
        end
      end
    end
  endfunction

  // Tick driver: holds a beat until taken, inserts random gaps between beats unless quiet.
  int unsigned tx_gap = 0;
  always @(posedge clk_i) begin
    bit nxt_valid;
    bit nxt_restart;
    nxt_valid = in_valid_i;
    nxt_restart = restart_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_row(restart_i);
        ticks_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (tick_queue.size() > 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            tx_gap = $urandom_range(0, 3);
          end else begin
            nxt_valid = 1'b1;
            nxt_restart = tick_queue.pop_front();
          end
        end
      end
    end
    in_valid_i <= nxt_valid;
    restart_i <= nxt_restart;
  end

  // Entry monitor with receiver stalls and the watchdog.
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;
  always @(posedge clk_i) begin
    entry_t exp_e;
    bit nxt_stall;
    bit moved;
    nxt_stall = 1'b0;
    moved = (in_valid_i && !in_stall_o) || (cfg_valid_i && cfg_ready_o);
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        entries_seen++;
        if (pending_entries.size() == 0) begin
          $display("%0t: unexpected entry row %0d col %0d", $time, got.row, got.col);
          errors++;
        end else begin
          exp_e = pending_entries.pop_front();
          if (got !== exp_e) begin
            $display("%0t: mismatch exp row %0d col %0d val %0d pos %0d d/r/m %b%b%b",
                     $time, exp_e.row, exp_e.col, exp_e.val, exp_e.pos,
                     exp_e.diag, exp_e.row_end, exp_e.mat_end);
            $display("%0t:          got row %0d col %0d val %0d pos %0d d/r/m %b%b%b",
                     $time, got.row, got.col, got.val, got.pos,
                     got.diag, got.row_end, got.mat_end);
            errors++;
          end
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        nxt_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        rx_gap = $urandom_range(0, 3);
        nxt_stall = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired, %0d entries outstanding", $time,
                 pending_entries.size());
        $display("[stencil_csr_row_generator] ERROR");
        $finish;
      end
    end
    out_stall_i <= nxt_stall;
  end

  task automatic wait_drained();
    while (tick_queue.size() > 0 || in_valid_i || pending_entries.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx <= scrg_pkg::REG_SIZE_Z) begin
      size_reg[idx] = v;
      restart_walk();
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_grid(input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y,
                          input logic [CFG_W-1:0] z);
    write_reg(scrg_pkg::REG_SIZE_X, x);
    write_reg(scrg_pkg::REG_SIZE_Y, y);
    write_reg(scrg_pkg::REG_SIZE_Z, z);
  endtask

  task automatic push_ticks(input int cnt, input int restart_odds);
    for (int i = 0; i < cnt; i++)
      tick_queue.push_back($urandom_range(0, restart_odds - 1) == 0);
  endtask

  initial begin
    size_reg = '{8'd1, 8'd1, 8'd1};
    restart_walk();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a single-point grid after reset, then a 3x3x3 walk with restarts.
    tick_queue = '{1'b0, 1'b1, 1'b0};
    wait_drained();
    set_grid(8'd3, 8'd3, 8'd3);
    for (int i = 0; i < 22; i++) tick_queue.push_back(i == 9 || i == 10);
    wait_drained();

    // A zero size acts as one, an oversized one as the maximum.
    set_grid(8'd0, 8'd2, 8'd1);
    push_ticks(6, 4);
    wait_drained();
    set_grid(8'd200, 8'd1, 8'd1);
    push_ticks(140, 50);
    wait_drained();

    // Back up the block behind a long receiver hold.
    set_grid(8'd2, 8'd2, 8'd2);
    hold_req = 1'b1;
    push_ticks(30, 12);
    wait_drained();

    // An unused register index must not disturb the walk.
    push_ticks(3, 1000);
    wait_drained();
    write_reg(REG_UNUSED, 8'hA5);
    push_ticks(10, 1000);
    wait_drained();

    set_grid(8'd4, 8'd5, 8'd3);
    push_ticks(80, 20);
    wait_drained();
    set_grid(8'd255, 8'd255, 8'd255);
    push_ticks(25, 8);
    wait_drained();
    set_grid(8'd1, 8'd128, 8'd2);
    push_ticks(50, 30);
    wait_drained();

    quiet = 1'b1;
    set_grid(8'd3, 8'd2, 8'd4);
    push_ticks(60, 15);
    wait_drained();

    $display("Walked grids from 1x1x1 to 128^3 with clamped sizes, restarts and stalls:");
    $display("%0d row ticks taken, %0d matrix entries checked.", ticks_taken, entries_seen);
    if (errors == 0 && pending_entries.size() == 0) begin
      $display("[stencil_csr_row_generator] OK");
    end else begin
      $display("[stencil_csr_row_generator] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/scrg_pkg.sv
rtl/scrg_sine.sv
rtl/scrg_queue.sv
rtl/scrg_front.sv
rtl/scrg_back.sv
rtl/stencil_csr_row_generator.sv
tb/tb_top.sv
